@@ hw/rtl/hbc_pkg.sv @@
// ----------------------------------------------------------------------------
// Histogram bucket counter package
// Shared widths, operation codes, controller states and the count memory
// control word.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned COUNT_W         = 64;
    localparam int unsigned INDEX_W         = 6;
    localparam int unsigned CFG_W           = 7;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned DEF_MAX_BUCKETS = 64;
    localparam int unsigned ACTIVE_RESET    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD    = 3'd0,
        OP_CLASSIFY  = 3'd1,
        OP_READ      = 3'd2,
        OP_OVERWRITE = 3'd3,
        OP_ADD       = 3'd4,
        OP_SUB       = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_DIV_BOUND = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_SRCH_RD   = 3'd1,
        S_SRCH_CMP  = 3'd2,
        S_FETCH     = 3'd3,
        S_MODIFY    = 3'd4,
        S_DIV_RD    = 3'd5,
        S_DIV_START = 3'd6,
        S_DIV_WAIT  = 3'd7
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic clear_all;
    } t_cnt_ctrl;

endpackage

@@ hw/rtl/hbc_intf.sv @@
// ----------------------------------------------------------------------------
// Histogram bucket counter channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hbc_in_if;
    import hbc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0]        bucket_index;
    logic [COUNT_W-1:0]        amount;
    logic                      bound_write;

    modport source (output valid, op, sample_value, bucket_index, amount, bound_write,
                    input ready);
    modport sink   (input valid, op, sample_value, bucket_index, amount, bound_write,
                    output ready);
endinterface

interface hbc_out_if;
    import hbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] bucket_found;
    logic [COUNT_W-1:0] count_value;
    logic               error;

    modport source (output valid, bucket_found, count_value, error, input ready);
    modport sink   (input valid, bucket_found, count_value, error, output ready);
endinterface

interface hbc_cfg_if;
    import hbc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] active_buckets;

    modport source (output valid, active_buckets, input ready);
    modport sink   (input valid, active_buckets, output ready);
endinterface

@@ hw/rtl/hbc_bound_mem.sv @@
// ----------------------------------------------------------------------------
// Bucket lower bound memory
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module hbc_bound_mem #(
    parameter int unsigned DEPTH = hbc_pkg::DEF_MAX_BUCKETS,
    parameter int unsigned AW    = $clog2(hbc_pkg::DEF_MAX_BUCKETS)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_addr,
    input  logic [hbc_pkg::VALUE_W-1:0] i_wdata,
    output logic [hbc_pkg::VALUE_W-1:0] o_rdata
);
    import hbc_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/hbc_count_mem.sv @@
// ----------------------------------------------------------------------------
// Bucket count memory
// Single-port synchronous memory with a valid bit per entry; an entry that
// is not valid reads as zero, so reset and clear take effect at once.
// ----------------------------------------------------------------------------
module hbc_count_mem #(
    parameter int unsigned DEPTH = hbc_pkg::DEF_MAX_BUCKETS,
    parameter int unsigned AW    = $clog2(hbc_pkg::DEF_MAX_BUCKETS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hbc_pkg::t_cnt_ctrl          i_ctrl,
    input  logic [AW-1:0]               i_addr,
    input  logic [hbc_pkg::COUNT_W-1:0] i_wdata,
    output logic [hbc_pkg::COUNT_W-1:0] o_rdata
);
    import hbc_pkg::*;

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rdata;
    logic [DEPTH-1:0]   r_vld;
    logic               r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            r_rvld <= r_vld[i_addr];
            if (i_ctrl.clear_all) begin
                r_vld <= '0;
            end else if (i_ctrl.wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

@@ hw/rtl/hbc_divider.sv @@
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hbc_divider #(
    parameter int unsigned W = hbc_pkg::COUNT_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_div;
    logic [W-1:0]  n_rem;
    logic [W-1:0]  n_quot;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    always_comb begin
        shifted = {r_rem, r_quot[W-1]};
        diff    = shifted - {1'b0, r_div};
        if (diff[W]) begin
            n_rem  = shifted[W-1:0];
            n_quot = {r_quot[W-2:0], 1'b0};
        end else begin
            n_rem  = diff[W-1:0];
            n_quot = {r_quot[W-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

@@ hw/rtl/histogram_bucket_counter_top.sv @@
// ----------------------------------------------------------------------------
// Histogram bucket counter
// Classifies signed samples into buckets by binary search over a bound
// memory and keeps per-bucket counts in a count memory.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  i_in     sink       op, sample_value, bucket_index, amount, bound_write
//  o_out    source     bucket_found, count_value, error
//  i_cfg    sink       active_buckets
//
//  One request is worked at a time. Record and classify search the bound
//  memory over the N active buckets, each probe taking a read state and a
//  compare state; the other operations pass through fetch and modify, and
//  divide first runs one pass of the divider per entry. Reset clears all
//  counts at once through per-entry valid bits. A waiting result does not
//  stop the next request, which then holds in its last cycle.
// ----------------------------------------------------------------------------
module histogram_bucket_counter_top #(
    parameter int unsigned MAX_BUCKETS = hbc_pkg::DEF_MAX_BUCKETS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hbc_in_if.sink    i_in,
    hbc_cfg_if.sink   i_cfg,
    hbc_out_if.source o_out
);
    import hbc_pkg::*;

    localparam int unsigned AW   = $clog2(MAX_BUCKETS);
    localparam int unsigned NW   = $clog2(MAX_BUCKETS + 1);
    localparam int unsigned IW   = (NW > INDEX_W) ? NW : INDEX_W;
    localparam int unsigned CMPW = (NW > CFG_W) ? NW : CFG_W;

    t_state             r_state,     n_state;
    logic [CFG_W-1:0]   r_active;
    t_op                r_op,        n_op;
    logic [VALUE_W-1:0] r_sample,    n_sample;
    logic [COUNT_W-1:0] r_amount,    n_amount;
    logic               r_bw,        n_bw;
    logic               r_err,       n_err;
    logic [IW-1:0]      r_idx,       n_idx;
    logic [NW-1:0]      r_first,     n_first;
    logic [NW-1:0]      r_len,       n_len;
    logic [AW-1:0]      r_sweep,     n_sweep;
    logic               r_out_valid, n_out_valid;
    logic [INDEX_W-1:0] r_out_found, n_out_found;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic               r_out_err,   n_out_err;

    logic [CMPW-1:0]    act_ext;
    logic [NW-1:0]      n_active;
    logic [NW-1:0]      half;
    logic [NW-1:0]      probe;
    logic               in_range;
    logic               cnt_write;
    logic [COUNT_W-1:0] upd_count;
    t_op                req_op;

    t_cnt_ctrl          cnt_ctrl;
    logic [AW-1:0]      cnt_addr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic [COUNT_W-1:0] cnt_rdata;
    logic               bnd_wr;
    logic [AW-1:0]      bnd_addr;
    logic [VALUE_W-1:0] bnd_rdata;
    logic               div_start;
    logic               div_done;
    logic [COUNT_W-1:0] div_quot;

    hbc_bound_mem #(
        .DEPTH (MAX_BUCKETS),
        .AW    (AW)
    ) u_bound_mem (
        .i_clk   (i_clk),
        .i_wr_en (bnd_wr),
        .i_addr  (bnd_addr),
        .i_wdata (r_sample),
        .o_rdata (bnd_rdata)
    );

    hbc_count_mem #(
        .DEPTH (MAX_BUCKETS),
        .AW    (AW)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (cnt_ctrl),
        .i_addr  (cnt_addr),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    hbc_divider #(
        .W (COUNT_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cnt_rdata),
        .i_divisor  (r_amount),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        act_ext = CMPW'(r_active);
        if (act_ext < CMPW'(2)) begin
            n_active = NW'(2);
        end else if (act_ext > CMPW'(MAX_BUCKETS)) begin
            n_active = NW'(MAX_BUCKETS);
        end else begin
            n_active = NW'(act_ext);
        end
        half     = r_len >> 1;
        probe    = r_first + half;
        in_range = (r_idx < IW'(MAX_BUCKETS));
        req_op   = t_op'(i_in.op);

        unique case (r_op)
            OP_RECORD, OP_ADD: upd_count = cnt_rdata + r_amount;
            OP_SUB:            upd_count = cnt_rdata - r_amount;
            OP_OVERWRITE:      upd_count = r_amount;
            default:           upd_count = cnt_rdata;
        endcase
        cnt_write = in_range && (r_op == OP_RECORD || r_op == OP_OVERWRITE ||
                                 r_op == OP_ADD || r_op == OP_SUB);
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sample    = r_sample;
        n_amount    = r_amount;
        n_bw        = r_bw;
        n_err       = r_err;
        n_idx       = r_idx;
        n_first     = r_first;
        n_len       = r_len;
        n_sweep     = r_sweep;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        cnt_ctrl    = '0;
        cnt_addr    = r_idx[AW-1:0];
        cnt_wdata   = upd_count;
        bnd_wr      = 1'b0;
        bnd_addr    = r_idx[AW-1:0];
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op     = req_op;
                    n_sample = i_in.sample_value;
                    n_amount = i_in.amount;
                    n_bw     = i_in.bound_write;
                    n_idx    = IW'(i_in.bucket_index);
                    n_err    = 1'b0;
                    n_first  = '0;
                    n_len    = n_active;
                    n_sweep  = '0;
                    priority if (req_op == OP_RECORD || req_op == OP_CLASSIFY) begin
                        n_state = S_SRCH_RD;
                    end else if (req_op == OP_CLEAR) begin
                        cnt_ctrl.clear_all = 1'b1;
                        n_state            = S_FETCH;
                    end else if (req_op == OP_DIV_BOUND && !i_in.bound_write &&
                                 i_in.amount == '0) begin
                        n_err   = 1'b1;
                        n_state = S_FETCH;
                    end else if (req_op == OP_DIV_BOUND && !i_in.bound_write) begin
                        n_state = S_DIV_RD;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_SRCH_RD: begin
                bnd_addr = probe[AW-1:0];
                if (r_len == '0) begin
                    n_idx   = (r_first == '0) ? '0 : IW'(r_first - NW'(1));
                    n_state = S_FETCH;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                bnd_addr = probe[AW-1:0];
                if ($signed(bnd_rdata) <= $signed(r_sample)) begin
                    n_first = probe + NW'(1);
                    n_len   = r_len - half - NW'(1);
                end else begin
                    n_len = half;
                end
                n_state = S_SRCH_RD;
            end
            S_FETCH: begin
                n_state = S_MODIFY;
            end
            S_MODIFY: begin
                if (!r_out_valid || o_out.ready) begin
                    cnt_ctrl.wr_en = cnt_write;
                    bnd_wr         = in_range && r_op == OP_DIV_BOUND && r_bw;
                    n_out_valid    = 1'b1;
                    n_out_found    = r_idx[INDEX_W-1:0];
                    n_out_count    = in_range ? upd_count : '0;
                    n_out_err      = r_err;
                    n_state        = S_IDLE;
                end
            end
            S_DIV_RD: begin
                cnt_addr = r_sweep;
                n_state  = S_DIV_START;
            end
            S_DIV_START: begin
                cnt_addr  = r_sweep;
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                cnt_addr = r_sweep;
                if (div_done) begin
                    cnt_ctrl.wr_en = 1'b1;
                    cnt_wdata      = div_quot;
                    if (r_sweep == AW'(MAX_BUCKETS - 1)) begin
                        n_state = S_FETCH;
                    end else begin
                        n_sweep = r_sweep + AW'(1);
                        n_state = S_DIV_RD;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= CFG_W'(ACTIVE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_active <= i_cfg.active_buckets;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_sample    <= n_sample;
        r_amount    <= n_amount;
        r_bw        <= n_bw;
        r_err       <= n_err;
        r_idx       <= n_idx;
        r_first     <= n_first;
        r_len       <= n_len;
        r_sweep     <= n_sweep;
        r_out_found <= n_out_found;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.bucket_found = r_out_found;
    assign o_out.count_value  = r_out_count;
    assign o_out.error        = r_out_err;

endmodule

@@ hw/rtl/hbc_checker.sv @@
// ----------------------------------------------------------------------------
// Histogram bucket counter port checker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module hbc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [hbc_pkg::INDEX_W-1:0] i_out_found,
    input logic [hbc_pkg::COUNT_W-1:0] i_out_count,
    input logic                        i_out_error
);
    import hbc_pkg::*;

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result word dropped before it was taken.");

    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_found) && $stable(i_out_count) && $stable(i_out_error))
        else $error("Stalled result word changed.");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid after reset.");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Request accepted while the previous one is still in work.");

    a_result_from_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("Result word appeared without a request in work.");

endmodule

bind histogram_bucket_counter_top hbc_checker u_hbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_found (o_out.bucket_found),
    .i_out_count (o_out.count_value),
    .i_out_error (o_out.error)
);
